/* sv/assert_macros.svh */
// Assertion macros for the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) else $error(msg);
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rstn, pre, post, msg)
`define ASSERT_NEXT(label, clk, rstn, pre, post, msg)
`endif
`endif

/* sv/bdab_pkg.sv */
// Shared types and constants for the button debounce and alarm beeper.
package bdab_pkg;

    localparam int NOW_W      = 32;
    localparam int CFG_W      = 16;
    localparam int RISK_W     = 4;
    localparam int STATE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 8;
    localparam int DIV_CNT_W  = 5;

    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_ON      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_PERIOD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_ON        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NOTICE_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_NOTICE_ON     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_NOTICE_RISK   = 3'd7;

    localparam logic [STATE_W-1:0] APP_OTHER       = 2'd0;
    localparam logic [STATE_W-1:0] APP_ALARM       = 2'd1;
    localparam logic [STATE_W-1:0] APP_NO_RESPONSE = 2'd2;
    localparam logic [STATE_W-1:0] APP_ACK_WAIT    = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } bdab_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } bdab_stat_t;

endpackage

/* sv/button_debounce_and_alarm_beeper_top.sv */
// Top level of the button debounce and alarm beeper.
//
// One input beat is one millisecond tick: s_tdata carries the timestamp and the
// raw button levels, s_tuser says whether the application status is valid.
// Each tick gives exactly one output beat with the two press events, the beep
// gate and the passive buzzer level.
// Registers are written on the cfg channel (index 0..7), which is always ready;
// write them only while no tick is in work.
// When a beep pattern is selected, the now_ms modulo period runs bit-serially,
// one bit per cycle, before the result is loaded into the output register;
// when no pattern applies, the result is loaded without it. A new tick is
// taken the cycle after the result is loaded into the output register.
// When m_tready is low the finished beat waits in the output register, and the
// next tick is worked on until its own result is ready to load.
// Reset (aresetn low, synchronous) restores register defaults and clears
// debounce and buzzer state; no output beat is pending afterward.
module button_debounce_and_alarm_beeper_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bdab_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdab_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now_ms[31:0], sos_raw[32], ack_raw[33], app_state[35:34], risk[39:36]
    input  logic [bdab_pkg::S_TDATA_W-1:0]  s_tdata,
    // status_present[0]
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // sos_press[0], ack_press[1], beep_gate[2], buzzer_level[3], zeros[7:4]
    output logic [bdab_pkg::M_TDATA_W-1:0]  m_tdata
);
    import bdab_pkg::*;

    bdab_cmd_t  cmd;
    bdab_stat_t stat;

    assign cfg_ready = 1'b1;

    bdab_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bdab_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* sv/bdab_ctrl.sv */
// Controller: accepts a tick, sequences the shared modulo unit, owns the output valid.
`include "assert_macros.svh"
module bdab_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    output bdab_pkg::bdab_cmd_t  cmd,
    input  bdab_pkg::bdab_stat_t stat
);
    import bdab_pkg::*;

    typedef enum logic [1:0] {IDLE, DIV, DONE} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        cmd.load   = (state_reg == IDLE) && s_tvalid;
        cmd.step   = (state_reg == DIV);
        cmd.finish = (state_reg == DONE) && (!out_valid_reg || m_tready);
    end

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    state_next = stat.need_div ? DIV : DONE;
                end
            end
            DIV: begin
                if (stat.div_last) begin
                    state_next = DONE;
                end
            end
            DONE: begin
                if (cmd.finish) begin
                    state_next     = IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `ASSERT_IMPLIES(a_finish_slot_free, aclk, aresetn, cmd.finish, !out_valid_reg || m_tready, "result written over a pending beat")
    `ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, cmd.load, !s_tready, "input taken while a tick is in work")
    `ASSERT_NEXT(a_div_ends, aclk, aresetn, cmd.step && stat.div_last, state_reg == DONE, "modulo did not end")
    `ASSERT_NEXT(a_finish_valid, aclk, aresetn, cmd.finish, m_tvalid, "finished tick not presented")

endmodule

/* sv/bdab_dp.sv */
// Datapath: config registers, debouncers, bit-serial modulo, beep gate and buzzer.
module bdab_dp (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [bdab_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bdab_pkg::CFG_W-1:0]         cfg_data,
    input  logic [bdab_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic [bdab_pkg::M_TDATA_W-1:0]     m_tdata,
    input  bdab_pkg::bdab_cmd_t                cmd,
    output bdab_pkg::bdab_stat_t               stat
);
    import bdab_pkg::*;

    logic [CFG_W-1:0]  debounce_reg, alarm_per_reg, alarm_on_reg;
    logic [CFG_W-1:0]  ack_per_reg, ack_on_reg, notice_per_reg, notice_on_reg;
    logic [RISK_W-1:0] notice_risk_reg;

    logic              sos_stable_reg, sos_last_reg, ack_stable_reg, ack_last_reg;
    logic [NOW_W-1:0]  sos_time_reg, ack_time_reg;
    logic              buzz_reg;
    logic [NOW_W-1:0]  buzz_time_reg;

    logic [NOW_W-1:0]     now_reg, quot_reg;
    logic [CFG_W-1:0]     rem_reg, period_reg, on_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 gate_en_reg, sos_ev_reg, ack_ev_reg;
    logic [3:0]           out_reg;

    logic [NOW_W-1:0]   in_now;
    logic               in_sos, in_ack;
    logic [STATE_W-1:0] in_state;
    logic [RISK_W-1:0]  in_risk;

    logic [NOW_W-1:0] sos_time_eff, ack_time_eff, sos_age, ack_age, dbnc_w;
    logic             sos_ev, ack_ev, sel_en;
    logic [CFG_W-1:0] sel_per, sel_on;
    logic [CFG_W:0]   rem_sh, rem_sub;
    logic [CFG_W-1:0] rem_next;
    logic             gate;

    assign in_now   = s_tdata[NOW_W-1:0];
    assign in_sos   = s_tdata[32];
    assign in_ack   = s_tdata[33];
    assign in_state = s_tdata[35:34];
    assign in_risk  = s_tdata[39:36];

    assign dbnc_w       = {{(NOW_W-CFG_W){1'b0}}, debounce_reg};
    assign sos_time_eff = (in_sos != sos_last_reg) ? in_now : sos_time_reg;
    assign ack_time_eff = (in_ack != ack_last_reg) ? in_now : ack_time_reg;
    assign sos_age      = in_now - sos_time_eff;
    assign ack_age      = in_now - ack_time_eff;
    assign sos_ev       = (in_sos != sos_stable_reg) && (sos_age >= dbnc_w);
    assign ack_ev       = (in_ack != ack_stable_reg) && (ack_age >= dbnc_w);

    always_comb begin
        sel_en  = 1'b0;
        sel_per = notice_per_reg;
        sel_on  = notice_on_reg;
        priority if (in_state == APP_ALARM || in_state == APP_NO_RESPONSE) begin
            sel_en  = 1'b1;
            sel_per = alarm_per_reg;
            sel_on  = alarm_on_reg;
        end else if (in_state == APP_ACK_WAIT) begin
            sel_en  = 1'b1;
            sel_per = ack_per_reg;
            sel_on  = ack_on_reg;
        end else if (in_risk >= notice_risk_reg) begin
            sel_en  = 1'b1;
        end else begin
            sel_en  = 1'b0;
        end
        sel_en = sel_en && s_tuser && (sel_per != '0);
    end

    assign stat.need_div = sel_en;
    assign stat.div_last = (cnt_reg == {DIV_CNT_W{1'b1}});

    assign rem_sh   = {rem_reg, quot_reg[NOW_W-1]};
    assign rem_sub  = rem_sh - {1'b0, period_reg};
    assign rem_next = (rem_sh >= {1'b0, period_reg}) ? rem_sub[CFG_W-1:0] : rem_sh[CFG_W-1:0];

    assign gate    = gate_en_reg && (rem_reg < on_reg);
    assign m_tdata = {{(M_TDATA_W-4){1'b0}}, out_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg    <= 16'd40;
            alarm_per_reg   <= 16'd400;
            alarm_on_reg    <= 16'd180;
            ack_per_reg     <= 16'd1000;
            ack_on_reg      <= 16'd120;
            notice_per_reg  <= 16'd2000;
            notice_on_reg   <= 16'd80;
            notice_risk_reg <= 4'd2;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_DEBOUNCE:      debounce_reg    <= cfg_data;
                REG_ALARM_PERIOD:  alarm_per_reg   <= cfg_data;
                REG_ALARM_ON:      alarm_on_reg    <= cfg_data;
                REG_ACK_PERIOD:    ack_per_reg     <= cfg_data;
                REG_ACK_ON:        ack_on_reg      <= cfg_data;
                REG_NOTICE_PERIOD: notice_per_reg  <= cfg_data;
                REG_NOTICE_ON:     notice_on_reg   <= cfg_data;
                REG_NOTICE_RISK:   notice_risk_reg <= cfg_data[RISK_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sos_stable_reg <= 1'b0;
            sos_last_reg   <= 1'b0;
            sos_time_reg   <= '0;
            ack_stable_reg <= 1'b0;
            ack_last_reg   <= 1'b0;
            ack_time_reg   <= '0;
            buzz_reg       <= 1'b0;
            buzz_time_reg  <= '0;
        end else begin
            if (cmd.load) begin
                sos_last_reg <= in_sos;
                sos_time_reg <= sos_time_eff;
                ack_last_reg <= in_ack;
                ack_time_reg <= ack_time_eff;
                if (sos_ev) begin
                    sos_stable_reg <= in_sos;
                end
                if (ack_ev) begin
                    ack_stable_reg <= in_ack;
                end
            end
            if (cmd.finish) begin
                if (!gate) begin
                    buzz_reg <= 1'b0;
                end else if (now_reg != buzz_time_reg) begin
                    buzz_reg      <= !buzz_reg;
                    buzz_time_reg <= now_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            now_reg     <= in_now;
            quot_reg    <= in_now;
            rem_reg     <= '0;
            cnt_reg     <= '0;
            period_reg  <= sel_per;
            on_reg      <= sel_on;
            gate_en_reg <= sel_en;
            sos_ev_reg  <= sos_ev && in_sos;
            ack_ev_reg  <= ack_ev && in_ack;
        end else if (cmd.step) begin
            quot_reg <= {quot_reg[NOW_W-2:0], 1'b0};
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg + 1'b1;
        end
        if (cmd.finish) begin
            out_reg <= {gate ? (now_reg != buzz_time_reg) ^ buzz_reg : 1'b0,
                        gate, ack_ev_reg, sos_ev_reg};
        end
    end

endmodule
